@@ src/hng_pkg.sv @@
// hng_pkg: widths, register indexes, reset values and word types of the
// hysteresis noise gate. No dependencies.
package hng_pkg;

  // Sample format, fixed by the word layout
  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_BITS_DEF = 24;
  localparam int THR_BITS      = 23;
  localparam int GAIN_FRAC     = 24;
  localparam int GAIN_W        = GAIN_FRAC + 1;

  // Signed operand width of the shared scaler and working width of the sums
  localparam int D_W = (SAMPLE_BITS + 2 > GAIN_W + 1) ? SAMPLE_BITS + 2 : GAIN_W + 1;
  localparam int WW  = D_W + 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC{1'b0}}};

  // Register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_HP_COEF    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LP_COEF    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ATTACK     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OPEN_RATE  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CLOSE_RATE = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_OPEN_THR   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CLOSE_THR  = 3'd7;

  localparam int NUM_COEFS = 6;
  localparam logic [31:0] COEF_RST [NUM_COEFS] = '{
    32'd216762, 32'd4952930, 32'd231400, 32'd1589, 32'd345900, 32'd1942
  };
  localparam logic [THR_BITS-1:0] OPEN_THR_RST  = 23'd8389;
  localparam logic [THR_BITS-1:0] CLOSE_THR_RST = 23'd3775;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] raw_sample;
    logic signed [SAMPLE_BITS-1:0] main_sample;
    logic                          gate_enable;
  } hng_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] gated_sample;
    logic                          gate_is_open;
  } hng_out_t;

endpackage

@@ src/hng_cfg_regs.sv @@
// hng_cfg_regs: coefficient and threshold registers of the noise gate.
// Depends on hng_pkg.
module hng_cfg_regs
  import hng_pkg::*;
#(
  parameter int COEF_BITS = COEF_BITS_DEF,
  parameter int CFG_W     = (COEF_BITS > THR_BITS) ? COEF_BITS : THR_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic [COEF_BITS-1:0] coef_o [NUM_COEFS],
  output logic [THR_BITS-1:0]  open_thr_o,
  output logic [THR_BITS-1:0]  close_thr_o
);

  logic [COEF_BITS-1:0] coef_q [NUM_COEFS];
  logic [THR_BITS-1:0]  open_thr_q, close_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef_q[i] <= COEF_BITS'(COEF_RST[i]);
      end
      open_thr_q  <= OPEN_THR_RST;
      close_thr_q <= CLOSE_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HP_COEF, REG_LP_COEF, REG_ATTACK, REG_RELEASE,
        REG_OPEN_RATE, REG_CLOSE_RATE: begin
          coef_q[cfg_idx_i] <= cfg_data_i[COEF_BITS-1:0];
        end
        REG_OPEN_THR: begin
          open_thr_q <= cfg_data_i[THR_BITS-1:0];
        end
        REG_CLOSE_THR: begin
          close_thr_q <= cfg_data_i[THR_BITS-1:0];
        end
      endcase
    end
  end

  assign coef_o      = coef_q;
  assign open_thr_o  = open_thr_q;
  assign close_thr_o = close_thr_q;

endmodule

@@ src/hng_scale_unit.sv @@
// hng_scale_unit: shared sign-magnitude scaler, sign(d) * floor(a * |d| / 2^k),
// result registered. Depends on hng_pkg.
module hng_scale_unit
  import hng_pkg::*;
#(
  parameter int COEF_BITS = COEF_BITS_DEF,
  parameter int A_W       = (COEF_BITS > GAIN_W) ? COEF_BITS : GAIN_W
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [A_W-1:0]        a_i,
  input  logic signed [D_W-1:0] d_i,
  input  logic                  gain_shift_i,  // shift by gain fraction, else coef
  output logic signed [D_W:0]   res_o
);

  logic             neg;
  logic [D_W-1:0]   mag;
  logic [A_W+D_W-1:0] prod, shifted;
  logic [D_W-1:0]   r;
  logic signed [D_W:0] res_q;

  always_comb begin
    neg     = d_i[D_W-1];
    mag     = neg ? D_W'(~d_i) + D_W'(1) : D_W'(d_i);
    prod    = (A_W + D_W)'(a_i) * (A_W + D_W)'(mag);
    shifted = gain_shift_i ? (prod >> GAIN_FRAC) : (prod >> COEF_BITS);
    r       = shifted[D_W-1:0];  // never exceeds |d|
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= neg ? -signed'({1'b0, r}) : signed'({1'b0, r});
    end
  end

  assign res_o = res_q;

endmodule

@@ src/hysteresis_noise_gate_core.sv @@
// hysteresis_noise_gate_core: top level of the sidechain noise gate with
// hysteresis. Depends on hng_pkg, hng_cfg_regs and hng_scale_unit.
//
// One input word carries a sidechain sample, a main sample and an enable bit;
// one output word carries the gated sample and the gate's open flag. With the
// enable bit set, the word runs five passes through a single shared scaler
// (high-pass pole, low-pass pole, envelope, gain easing, final gain multiply),
// each pass a multiply state followed by an update of the state it feeds,
// and a last state hands the result to the output register; a new word is
// taken only once the sequencer is back in idle. A word with the enable bit
// clear passes the main sample through untouched and leaves all filter and
// gain state as it was. in_stall_o is low only while the sequencer is idle;
// the output register holds a finished word while out_stall_i is high, and
// the sequencer waits for it before taking more.
// Configuration registers may be written only while no word is in flight.
module hysteresis_noise_gate_core
  import hng_pkg::*;
#(
  parameter int COEF_BITS = COEF_BITS_DEF,
  localparam int CFG_W    = (COEF_BITS > THR_BITS) ? COEF_BITS : THR_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hng_in_t              in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hng_out_t             out_word_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int S     = SAMPLE_BITS;
  localparam int A_W   = (COEF_BITS > GAIN_W) ? COEF_BITS : GAIN_W;
  localparam int CMP_W = SAMPLE_BITS + THR_BITS;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;  // scaler busy
  localparam logic [1:0] ST_UPD  = 2'd2;  // fold scaler result into state
  localparam logic [1:0] ST_DONE = 2'd3;  // hand result to output register

  // Passes through the scaler
  localparam logic [2:0] STP_HP   = 3'd0;
  localparam logic [2:0] STP_LP   = 3'd1;
  localparam logic [2:0] STP_ENV  = 3'd2;
  localparam logic [2:0] STP_GAIN = 3'd3;
  localparam logic [2:0] STP_FIN  = 3'd4;

  function automatic logic signed [S-1:0] sat_s(input logic signed [WW-1:0] v);
    logic fits;
    fits = (v[WW-1:S-1] == '0) || (v[WW-1:S-1] == '1);
    if (fits) begin
      return v[S-1:0];
    end else if (v[WW-1]) begin
      return {1'b1, {(S-1){1'b0}}};
    end else begin
      return {1'b0, {(S-1){1'b1}}};
    end
  endfunction

  // Configuration
  logic [COEF_BITS-1:0] coef [NUM_COEFS];
  logic [THR_BITS-1:0]  open_thr, close_thr;

  hng_cfg_regs #(
    .COEF_BITS (COEF_BITS),
    .CFG_W     (CFG_W)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef),
    .open_thr_o  (open_thr),
    .close_thr_o (close_thr)
  );

  // Control and filter state
  logic [1:0]             state_q, state_d;
  logic [2:0]             step_q, step_d;
  logic                   out_valid_q, out_valid_d;
  logic signed [S-1:0]    hp_q, hp_d;
  logic signed [S-1:0]    lp_q, lp_d;
  logic [S-1:0]           env_q, env_d;
  logic [GAIN_W-1:0]      gain_q, gain_d;
  logic                   open_q, open_d;

  // Word payload
  logic signed [S-1:0]    raw_q, raw_d;
  logic signed [S-1:0]    main_q, main_d;
  logic signed [D_W-1:0]  d_q, d_d;
  logic [A_W-1:0]         a_q, a_d;
  logic                   gshift_q, gshift_d;
  logic signed [S-1:0]    res_q, res_d;
  hng_out_t               out_word_q, out_word_d;

  logic signed [D_W:0]    s_res;

  hng_scale_unit #(
    .COEF_BITS (COEF_BITS),
    .A_W       (A_W)
  ) u_scale (
    .clk_i        (clk_i),
    .en_i         (state_q == ST_MUL),
    .a_i          (a_q),
    .d_i          (d_q),
    .gain_shift_i (gshift_q),
    .res_o        (s_res)
  );

  // Update arithmetic, one pass uses its own slice
  logic signed [WW-1:0]   hp_sum, lp_sum, env_sum, gain_sum;
  logic signed [S-1:0]    hp_new, lp_new, fin_res;
  logic signed [S:0]      hp_out;
  logic signed [S+1:0]    lp_diff;
  logic [S-1:0]           abs_lp, env_new;
  logic signed [S:0]      env_diff;
  logic [CMP_W-1:0]       env_cmp, open_cmp, close_cmp;
  logic                   open_new;
  logic [GAIN_W-1:0]      target, gain_new;
  logic signed [GAIN_W:0] gain_diff;

  always_comb begin
    hp_sum   = WW'(hp_q) + WW'(s_res);
    hp_new   = sat_s(hp_sum);
    hp_out   = (S+1)'(raw_q) - (S+1)'(hp_new);
    lp_diff  = (S+2)'(hp_out) - (S+2)'(lp_q);

    lp_sum   = WW'(lp_q) + WW'(s_res);
    lp_new   = sat_s(lp_sum);
    abs_lp   = lp_new[S-1] ? S'(~lp_new) + S'(1) : S'(lp_new);
    env_diff = signed'({1'b0, abs_lp}) - signed'({1'b0, env_q});

    // envelope moves toward |lp| without overshoot, so it stays in range
    env_sum  = WW'(signed'({1'b0, env_q})) + WW'(s_res);
    env_new  = env_sum[S-1:0];

    // thresholds carry 23 fraction bits, the envelope S-1
    env_cmp   = CMP_W'(env_new) << THR_BITS;
    open_cmp  = CMP_W'(open_thr) << (S - 1);
    close_cmp = CMP_W'(close_thr) << (S - 1);
    open_new  = open_q ? (env_cmp >= close_cmp) : (env_cmp >= open_cmp);

    target    = open_new ? GAIN_ONE : '0;
    gain_diff = signed'({1'b0, target}) - signed'({1'b0, gain_q});

    gain_sum = WW'(signed'({1'b0, gain_q})) + WW'(s_res);
    priority if (gain_sum[WW-1]) begin
      gain_new = '0;
    end else if (gain_sum > WW'(GAIN_ONE)) begin
      gain_new = GAIN_ONE;
    end else begin
      gain_new = gain_sum[GAIN_W-1:0];
    end

    fin_res = sat_s(WW'(s_res));
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    hp_d        = hp_q;
    lp_d        = lp_q;
    env_d       = env_q;
    gain_d      = gain_q;
    open_d      = open_q;
    raw_d       = raw_q;
    main_d      = main_q;
    d_d         = d_q;
    a_d         = a_q;
    gshift_d    = gshift_q;
    res_d       = res_q;
    out_word_d  = out_word_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          raw_d  = in_word_i.raw_sample;
          main_d = in_word_i.main_sample;
          if (in_word_i.gate_enable) begin
            d_d      = D_W'(in_word_i.raw_sample) - D_W'(hp_q);
            a_d      = A_W'(coef[REG_HP_COEF]);
            gshift_d = 1'b0;
            step_d   = STP_HP;
            state_d  = ST_MUL;
          end else begin
            // bypass: main sample out, state untouched
            res_d   = in_word_i.main_sample;
            state_d = ST_DONE;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        state_d = ST_MUL;
        unique case (step_q)
          STP_HP: begin
            hp_d   = hp_new;
            d_d    = D_W'(lp_diff);
            a_d    = A_W'(coef[REG_LP_COEF]);
            step_d = STP_LP;
          end
          STP_LP: begin
            lp_d   = lp_new;
            d_d    = D_W'(env_diff);
            a_d    = (abs_lp > env_q) ? A_W'(coef[REG_ATTACK]) : A_W'(coef[REG_RELEASE]);
            step_d = STP_ENV;
          end
          STP_ENV: begin
            env_d  = env_new;
            open_d = open_new;
            d_d    = D_W'(gain_diff);
            a_d    = (target > gain_q) ? A_W'(coef[REG_OPEN_RATE])
                                       : A_W'(coef[REG_CLOSE_RATE]);
            step_d = STP_GAIN;
          end
          STP_GAIN: begin
            gain_d   = gain_new;
            d_d      = D_W'(main_q);
            a_d      = A_W'(gain_new);
            gshift_d = 1'b1;
            step_d   = STP_FIN;
          end
          STP_FIN: begin
            res_d   = fin_res;
            state_d = ST_DONE;
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d             = 1'b1;
          out_word_d.gated_sample = res_q;
          out_word_d.gate_is_open = open_q;
          state_d                 = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STP_HP;
      out_valid_q <= 1'b0;
      hp_q        <= '0;
      lp_q        <= '0;
      env_q       <= '0;
      gain_q      <= '0;
      open_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      hp_q        <= hp_d;
      lp_q        <= lp_d;
      env_q       <= env_d;
      gain_q      <= gain_d;
      open_q      <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q      <= raw_d;
    main_q     <= main_d;
    d_q        <= d_d;
    a_q        <= a_d;
    gshift_q   <= gshift_d;
    res_q      <= res_d;
    out_word_q <= out_word_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ src/hng_checker.sv @@
// hng_checker: port-level assertions for hysteresis_noise_gate_core, bound
// to the top level below. Depends on hng_pkg.
module hng_checker
  import hng_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input hng_in_t  in_word_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input hng_out_t out_word_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed under stall");

  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken while a word is in flight");

  // a new output word only comes from a busy sequencer
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word without work behind it");

  // bypass word goes through the done state to the output with the main sample unchanged
  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_word_i.gate_enable && !out_valid_o |->
      ##2 out_valid_o && (out_word_o.gated_sample == $past(in_word_i.main_sample, 2)))
    else $error("bypass word wrong or late");

endmodule

bind hysteresis_noise_gate_core hng_checker u_hng_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
